@@ hdl/rrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared codes and control types for the round-robin ready ring.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int PORT_ID_W = 16;
  localparam int LENGTH_W = 5;

  localparam logic [ACTION_W-1:0] ACT_ADMIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NEXT   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // per-transaction operation broadcast to every cell
  typedef struct packed {
    logic admit;   // write id into the first free cell
    logic remove;  // close the gap at the first matching cell
    logic rotate;  // move every entry one place toward the head
  } rrr_ctl_t;

endpackage

@@ hdl/rrr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrr_cell
// One slot of the ring: holds an id, compares it, takes its neighbor's id.
// ----------------------------------------------------------------------------
module rrr_cell #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16,
  parameter int INDEX    = 0
) (
  input  logic                       clk,
  input  rrr_pkg::rrr_ctl_t          ctl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic [ID_WIDTH-1:0]        id,
  input  logic [ID_WIDTH-1:0]        head,
  input  logic [ID_WIDTH-1:0]        neighbor,
  input  logic                       found_in,
  output logic                       found_out,
  output logic [ID_WIDTH-1:0]        entry
);

  localparam int CW = $clog2(DEPTH + 1);

  logic valid;
  logic is_free;
  logic is_last;
  logic hit;

  assign valid     = CW'(INDEX) < count;
  assign is_free   = CW'(INDEX) == count;
  assign is_last   = CW'(INDEX + 1) == count;
  assign hit       = valid && (entry == id);
  assign found_out = found_in || hit;

  always_ff @(posedge clk) begin
    if (ctl.admit && is_free) begin
      entry <= id;
    end else if (ctl.remove && found_out) begin
      entry <= neighbor;
    end else if (ctl.rotate && valid) begin
      entry <= is_last ? head : neighbor;
    end
  end

endmodule

@@ hdl/round_robin_ready_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_ring
// Ordered ring of task ids with the head in cell 0: admit, remove, next.
// ----------------------------------------------------------------------------
// result: done strobes in the cycle after start
// throughput: one transaction per cycle, busy never rises
// reset: rst clears the entry count and the result strobe; cell contents
//   are left as they are and only entries below the count are ever used
// the receiver cannot stall, so no result is ever held back
// ----------------------------------------------------------------------------
module round_robin_ready_ring #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rrr_pkg::ACTION_W-1:0]      action,
  input  logic [rrr_pkg::PORT_ID_W-1:0]     task_id,
  output logic                              done,
  output logic [rrr_pkg::STATUS_W-1:0]      status,
  output logic [rrr_pkg::PORT_ID_W-1:0]     chosen_id,
  output logic [rrr_pkg::LENGTH_W-1:0]      ring_length
);

  localparam int CW = $clog2(DEPTH + 1);

  // entry count and derived ring flags
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                empty;
  logic                full;

  // cell chain
  logic [ID_WIDTH-1:0] id;
  logic [ID_WIDTH-1:0] entry [DEPTH];
  logic [ID_WIDTH-1:0] neighbor [DEPTH];
  logic [DEPTH:0]      found;
  rrr_pkg::rrr_ctl_t   ctl;

  // result staging
  logic [rrr_pkg::STATUS_W-1:0] status_next;
  logic [ID_WIDTH-1:0]          chosen_next;

  // never stalls: busy is tied low
  assign busy = 1'b0;

  // only the low ID_WIDTH bits of the id take part
  assign id    = ID_WIDTH'(task_id);
  assign empty = count == '0;
  assign full  = count == CW'(DEPTH);

  // operation broadcast, gated by the ring flags
  always_comb begin
    ctl = '0;
    if (start) begin
      case (action)
        rrr_pkg::ACT_ADMIT:  ctl.admit  = !full;
        rrr_pkg::ACT_REMOVE: ctl.remove = !empty;
        rrr_pkg::ACT_NEXT:   ctl.rotate = !empty;
        default: ctl = '0;
      endcase
    end
  end

  // first-match search ripples from the head toward the tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign neighbor[i] = entry[i];
    end else begin : g_mid
      assign neighbor[i] = entry[i+1];
    end

    rrr_cell #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .id        (id),
      .head      (entry[0]),
      .neighbor  (neighbor[i]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .entry     (entry[i])
    );
  end

  // status, new head and count for this transaction
  always_comb begin
    count_next  = count;
    status_next = rrr_pkg::ST_OK;
    chosen_next = '0;
    case (action)
      rrr_pkg::ACT_ADMIT: begin
        if (full) begin
          status_next = rrr_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      rrr_pkg::ACT_REMOVE: begin
        if (empty) begin
          status_next = rrr_pkg::ST_EMPTY;
        end else if (!found[DEPTH]) begin
          status_next = rrr_pkg::ST_NOT_FOUND;
        end else begin
          count_next = count - CW'(1);
        end
      end
      rrr_pkg::ACT_NEXT: begin
        if (empty) begin
          status_next = rrr_pkg::ST_EMPTY;
        end else if (count == CW'(1)) begin
          // single entry: head stays put
          chosen_next = entry[0];
        end else begin
          chosen_next = entry[1];
        end
      end
      default: begin
        // unused code: no change, plain ok
        status_next = rrr_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  // result payload, meaningful only while done is high
  always_ff @(posedge clk) begin
    if (start) begin
      status      <= status_next;
      chosen_id   <= rrr_pkg::PORT_ID_W'(chosen_next);
      ring_length <= rrr_pkg::LENGTH_W'(count_next);
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin ready ring (admit, remove, next).
// A directed table covers the edge cases: empty ring, full ring, duplicate ids,
// missing ids, removing the head, a single entry, and the unused action code.
// Random traffic follows, alternating fill-heavy and drain-heavy stretches
// under several sender idle settings. Each accepted transaction runs through
// an in-bench ring predictor. Every done strobe is compared, field by field,
// with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RING_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 500;
  localparam int BURST_LEN    = 60;     // fill/drain bias flips this often
  localparam int DRAIN_CYCLES = 8;      // extra wait after the last result, plenty of margin
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  // action code 3 has no name in the package; the ring ignores it
  localparam logic [rrr_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [rrr_pkg::STATUS_W-1:0]  status;
    logic [rrr_pkg::PORT_ID_W-1:0] chosen;
    logic [rrr_pkg::LENGTH_W-1:0]  length;
  } ring_result_t;

  // one row of the directed table; typed rows carry a hand-written result
  typedef struct {
    logic [rrr_pkg::ACTION_W-1:0]  action;
    logic [rrr_pkg::PORT_ID_W-1:0] id;
    bit                            typed;
    ring_result_t                  want;
  } directed_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [rrr_pkg::ACTION_W-1:0]  action = '0;
  logic [rrr_pkg::PORT_ID_W-1:0] task_id = '0;
  logic                          busy;
  logic                          done;
  logic [rrr_pkg::STATUS_W-1:0]  status;
  logic [rrr_pkg::PORT_ID_W-1:0] chosen_id;
  logic [rrr_pkg::LENGTH_W-1:0]  ring_length;

  round_robin_ready_ring #(
    .DEPTH   (RING_DEPTH),
    .ID_WIDTH(rrr_pkg::PORT_ID_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .task_id    (task_id),
    .done       (done),
    .status     (status),
    .chosen_id  (chosen_id),
    .ring_length(ring_length)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predictor state: the ring in order from the head ----
  logic [rrr_pkg::PORT_ID_W-1:0] ready_ids [RING_DEPTH];
  int                            ready_count = 0;

  // expected results, oldest first
  ring_result_t         pending_results [$];
  directed_row_t        directed_rows [$];

  int cycle_count   = 0;
  int mismatches    = 0;
  int checked       = 0;
  int directed_sent = 0;
  int random_sent   = 0;
  int seen_full     = 0;
  int seen_empty    = 0;
  int seen_missing  = 0;
  int seen_next     = 0;

  // apply one transaction to the predicted ring and return its result
  function automatic ring_result_t schedule_action(
      logic [rrr_pkg::ACTION_W-1:0] act, logic [rrr_pkg::PORT_ID_W-1:0] id);
    ring_result_t                  res;
    int                            hit;
    logic [rrr_pkg::PORT_ID_W-1:0] old_head;
    res.status = rrr_pkg::ST_OK;
    res.chosen = '0;
    hit = -1;
    case (act)
      rrr_pkg::ACT_ADMIT: begin
        // new id goes to the tail, the far end from the head
        if (ready_count >= RING_DEPTH) begin
          res.status = rrr_pkg::ST_FULL;
        end else begin
          ready_ids[ready_count] = id;
          ready_count++;
        end
      end
      rrr_pkg::ACT_REMOVE: begin
        if (ready_count == 0) begin
          res.status = rrr_pkg::ST_EMPTY;
        end else begin
          // first match from the head onward, then close the gap
          for (int i = 0; i < ready_count; i++) begin
            if (hit < 0 && ready_ids[i] == id) hit = i;
          end
          if (hit < 0) begin
            res.status = rrr_pkg::ST_NOT_FOUND;
          end else begin
            for (int i = hit; i < ready_count - 1; i++) ready_ids[i] = ready_ids[i + 1];
            ready_count--;
          end
        end
      end
      rrr_pkg::ACT_NEXT: begin
        if (ready_count == 0) begin
          res.status = rrr_pkg::ST_EMPTY;
        end else begin
          // rotate: old head goes to the tail
          old_head = ready_ids[0];
          for (int i = 0; i < ready_count - 1; i++) ready_ids[i] = ready_ids[i + 1];
          ready_ids[ready_count - 1] = old_head;
          res.chosen = ready_ids[0];
        end
      end
      default: begin
        // unused code: nothing changes
      end
    endcase
    res.length = rrr_pkg::LENGTH_W'(ready_count);
    return res;
  endfunction

  function automatic void add_row(logic [rrr_pkg::ACTION_W-1:0] act,
                                  logic [rrr_pkg::PORT_ID_W-1:0] id,
                                  bit typed, logic [rrr_pkg::STATUS_W-1:0] st,
                                  logic [rrr_pkg::PORT_ID_W-1:0] chosen, int len);
    directed_row_t row;
    row.action      = act;
    row.id          = id;
    row.typed       = typed;
    row.want.status = st;
    row.want.chosen = chosen;
    row.want.length = rrr_pkg::LENGTH_W'(len);
    directed_rows.push_back(row);
  endfunction

  // drive one transaction, with random idle cycles ahead of it, and
  // record the expected result once the ring accepts it
  task automatic issue(input logic [rrr_pkg::ACTION_W-1:0] act,
                       input logic [rrr_pkg::PORT_ID_W-1:0] id,
                       input int idle_pct, input bit typed, input ring_result_t want);
    ring_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      // junk on the payload while start is low must be ignored
      start   <= 1'b0;
      action  <= rrr_pkg::ACTION_W'($urandom);
      task_id <= rrr_pkg::PORT_ID_W'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    action  <= act;
    task_id <= id;
    // accepted at the first edge with busy low
    do @(posedge clk); while (busy);
    predicted = schedule_action(act, id);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // pick a random transaction; removes mostly name ids in the ring
  task automatic random_item(input bit filling, output logic [rrr_pkg::ACTION_W-1:0] act,
                             output logic [rrr_pkg::PORT_ID_W-1:0] id);
    int roll;
    roll = $urandom_range(99);
    // small id pool half the time so duplicates show up
    id = ($urandom_range(1) != 0) ? rrr_pkg::PORT_ID_W'($urandom)
                                  : rrr_pkg::PORT_ID_W'($urandom_range(7));
    if (roll < 4) begin
      act = ACT_UNUSED;
    end else if (roll < (filling ? 60 : 24)) begin
      act = rrr_pkg::ACT_ADMIT;
    end else if (roll < (filling ? 78 : 76)) begin
      act = rrr_pkg::ACT_REMOVE;
      if (ready_count > 0 && $urandom_range(9) != 0)
        id = ready_ids[$urandom_range(ready_count - 1)];
    end else begin
      act = rrr_pkg::ACT_NEXT;
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
               field, cycle_count, want, got);
  endtask

  // ---- result checker: done is a one-cycle strobe, no back-pressure ----
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result at cycle %0d with no transaction outstanding", cycle_count);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.status == rrr_pkg::ST_FULL) seen_full++;
        if (want.status == rrr_pkg::ST_EMPTY) seen_empty++;
        if (want.status == rrr_pkg::ST_NOT_FOUND) seen_missing++;
        if (want.chosen != '0) seen_next++;
        if (status !== want.status) report_mismatch("status", want.status, status);
        if (chosen_id !== want.chosen) report_mismatch("chosen_id", want.chosen, chosen_id);
        if (ring_length !== want.length) report_mismatch("ring_length", want.length, ring_length);
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---- stimulus ----
  initial begin
    logic [rrr_pkg::ACTION_W-1:0]  act;
    logic [rrr_pkg::PORT_ID_W-1:0] id;
    int                            idle_setting [3];
    ring_result_t                  none;

    none = '0;
    idle_setting = '{0, 48, 10};

    // empty ring cases and the ignored code
    add_row(rrr_pkg::ACT_NEXT,   16'h0000, 1, rrr_pkg::ST_EMPTY,     16'h0000, 0);
    add_row(rrr_pkg::ACT_REMOVE, 16'h1234, 1, rrr_pkg::ST_EMPTY,     16'h0000, 0);
    add_row(ACT_UNUSED,          16'hFFFF, 1, rrr_pkg::ST_OK,        16'h0000, 0);
    // single entry: next keeps the same head
    add_row(rrr_pkg::ACT_ADMIT,  16'hFFFF, 1, rrr_pkg::ST_OK,        16'h0000, 1);
    add_row(rrr_pkg::ACT_NEXT,   16'h0000, 1, rrr_pkg::ST_OK,        16'hFFFF, 1);
    // zero id, then a duplicate admit
    add_row(rrr_pkg::ACT_ADMIT,  16'h0000, 1, rrr_pkg::ST_OK,        16'h0000, 2);
    add_row(rrr_pkg::ACT_ADMIT,  16'hFFFF, 1, rrr_pkg::ST_OK,        16'h0000, 3);
    add_row(rrr_pkg::ACT_REMOVE, 16'hA5A5, 1, rrr_pkg::ST_NOT_FOUND, 16'h0000, 3);
    // head removal, then a rotate over the rest
    add_row(rrr_pkg::ACT_REMOVE, 16'hFFFF, 0, rrr_pkg::ST_OK,        16'h0000, 0);
    add_row(rrr_pkg::ACT_NEXT,   16'h0000, 0, rrr_pkg::ST_OK,        16'h0000, 0);
    // fill to the top with walking-one ids
    for (int k = 0; k < RING_DEPTH - 2; k++)
      add_row(rrr_pkg::ACT_ADMIT, rrr_pkg::PORT_ID_W'(1 << k), 0, rrr_pkg::ST_OK,
              16'h0000, 0);
    add_row(rrr_pkg::ACT_ADMIT,  16'h5A5A, 1, rrr_pkg::ST_FULL,      16'h0000, RING_DEPTH);
    add_row(ACT_UNUSED,          16'h0001, 1, rrr_pkg::ST_OK,        16'h0000, RING_DEPTH);

    // reset held once, then released
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      issue(directed_rows[r].action, directed_rows[r].id, 0,
            directed_rows[r].typed, directed_rows[r].want);
      directed_sent++;
    end

    // random traffic in three idle phases, bias flipping every burst
    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < RANDOM_ITEMS / 3 + 1; n++) begin
        random_item(((n / BURST_LEN) % 2) == 0, act, id);
        issue(act, id, idle_setting[p], 1'b0, none);
        random_sent++;
      end
    end
    start <= 1'b0;

    // let the last results come back
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d transactions (%0d directed, %0d random) at idle rates 0/48/10",
             checked, directed_sent, random_sent);
    $display("full ring %0d, empty ring %0d, id missing %0d, next with nonzero id %0d",
             seen_full, seen_empty, seen_missing, seen_next);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rrr_pkg.sv
hdl/rrr_cell.sv
hdl/round_robin_ready_ring.sv
verif/testbench.sv
